FILE: hdl/pva_pkg.sv
// Package for the polyphonic voice allocator: stream packing widths, command
// and controller codes, item kinds, sequencer states and result structs.
// No dependencies.
package pva_pkg;

   // Stream payload widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   // Voice table entry: fixed fields below the age stamp
   localparam int ENT_FIXED_W = 14;

   // Command codes
   localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [1:0] CMD_CTRL     = 2'd2;

   // Controller numbers and the pedal threshold
   localparam logic [6:0] CC_SUSTAIN   = 7'd64;
   localparam logic [6:0] CC_SOUND_OFF = 7'd120;
   localparam logic [6:0] CC_NOTES_OFF = 7'd123;
   localparam logic [6:0] PEDAL_THRESH = 7'd64;

   // Result actions
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      KIND_DONE,
      KIND_ON,
      KIND_OFF,
      KIND_PEDAL,
      KIND_ALL_OFF
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ONWR,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [2:0] voice_index;
      logic       action;
      logic [6:0] out_key;
      logic [3:0] out_chan;
      logic [6:0] out_velocity;
      logic       stolen;
   } result_type;

   // Sequencer to result buffer
   typedef struct packed {
      logic       push;
      logic       flush;
      result_type res;
   } buf_ctl_type;

endpackage

FILE: hdl/pva_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pva_ram #(
   parameter int WIDTH = 46,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pva_rsp_buf.sv
// Result buffer: holds one pending result until the next one (or the end of
// the scan) tells whether it is final, then drives the rsp stream. Uses pva_pkg.
module pva_rsp_buf (
   input  logic                            clock,
   input  logic                            reset,
   input  pva_pkg::buf_ctl_type            ctl,
   output logic                            ready,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // voice_index[2:0], out_key[9:3], out_chan[13:10], out_velocity[20:14]
   output logic [pva_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // action[0], stolen[1]
   output logic [pva_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);

   logic                pend_valid_ff, pend_valid_in;
   pva_pkg::result_type pend_res_ff, pend_res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pva_pkg::result_type rsp_res_ff, rsp_res_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_free;
   logic                move;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign ready    = !pend_valid_ff || rsp_free;
   assign move     = (ctl.push || ctl.flush) && pend_valid_ff && rsp_free;

   // Next values
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_res_in   = pend_res_ff;
      if (ctl.push && ready) begin
         pend_valid_in = 1'b1;
         pend_res_in   = ctl.res;
      end else if (ctl.flush && ready) begin
         pend_valid_in = 1'b0;
      end
      rsp_res_in  = rsp_res_ff;
      rsp_last_in = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = pend_res_ff;
         rsp_last_in  = ctl.flush;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_res_ff <= pend_res_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Stream packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_res_ff.out_velocity, rsp_res_ff.out_chan,
                        rsp_res_ff.out_key, rsp_res_ff.voice_index};
   assign rsp_tuser  = {rsp_res_ff.stolen, rsp_res_ff.action};

   // A non-final result on the bus always has a successor waiting
   a_nonfinal_has_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> pend_valid_ff)
      else $error("non-final result without pending successor");

   // A completed flush leaves nothing pending
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.flush && ready |=> !pend_valid_ff)
      else $error("pending result left after flush");

endmodule

FILE: hdl/pva_ctrl.sv
// Event sequencer: decodes events, scans the voice table RAM one slot per
// cycle unless a result push stalls, writes back modified slots and hands results to the buffer.
// Uses pva_pkg; drives a pva_ram instance and pva_rsp_buf.
module pva_ctrl #(
   parameter int NUM_VOICES = 8,
   parameter int AGE_BITS   = 32,
   localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
   localparam int ENT_W = AGE_BITS + pva_pkg::ENT_FIXED_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pva_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pva_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           ram_we,
   output logic [IDX_W-1:0]               ram_waddr,
   output logic [ENT_W-1:0]               ram_wdata,
   output logic [IDX_W-1:0]               ram_raddr,
   input  logic [ENT_W-1:0]               ram_rdata,
   output pva_pkg::buf_ctl_type           buf_ctl,
   input  logic                           buf_ready
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

   // Entry bit positions
   localparam int ACT_B   = 0;
   localparam int SUS_B   = 1;
   localparam int HELD_B  = 2;
   localparam int CHAN_LO = 3;
   localparam int KEY_LO  = 7;
   localparam int AGE_LO  = 14;

   // Request fields
   logic [1:0] req_command;
   logic       req_done;
   logic [3:0] req_chan;
   logic [6:0] req_key;
   logic [6:0] req_velocity;
   logic [6:0] req_ccn;
   logic [6:0] req_ccv;
   logic [2:0] req_fin;

   assign req_command  = req_tuser[1:0];
   assign req_done     = req_tuser[2];
   assign req_chan     = req_tdata[3:0];
   assign req_key      = req_tdata[10:4];
   assign req_velocity = req_tdata[17:11];
   assign req_ccn      = req_tdata[24:18];
   assign req_ccv      = req_tdata[31:25];
   assign req_fin      = req_tdata[34:32];

   pva_pkg::state_type state_ff, state_in;
   pva_pkg::kind_type  kind_ff, kind_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   end_ff, end_in;
   logic [6:0]         key_ff, key_in;
   logic [3:0]         chan_ff, chan_in;
   logic [6:0]         vel_ff, vel_in;
   logic [15:0]        pedal_ff, pedal_in;
   logic [NUM_VOICES-1:0] valid_ff, valid_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               best_held_ff, best_held_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;
   logic [AGE_BITS-1:0] age_ctr_ff, age_ctr_in;

   // Event decode at the request
   pva_pkg::kind_type dec_kind;
   logic              dec_work;
   logic [IDX_W-1:0]  dec_start;
   logic              accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      dec_kind  = pva_pkg::KIND_OFF;
      dec_work  = 1'b0;
      dec_start = '0;
      if (req_done) begin
         dec_kind  = pva_pkg::KIND_DONE;
         dec_work  = (32'(req_fin) < NUM_VOICES);
         dec_start = IDX_W'(req_fin);
      end else begin
         case (req_command)
            pva_pkg::CMD_NOTE_ON: begin
               dec_work = 1'b1;
               dec_kind = (req_velocity != 7'd0) ? pva_pkg::KIND_ON : pva_pkg::KIND_OFF;
            end
            pva_pkg::CMD_NOTE_OFF: begin
               dec_work = 1'b1;
               dec_kind = pva_pkg::KIND_OFF;
            end
            pva_pkg::CMD_CTRL: begin
               if (req_ccn == pva_pkg::CC_SUSTAIN) begin
                  dec_kind = pva_pkg::KIND_PEDAL;
                  dec_work = pedal_ff[req_chan] && (req_ccv < pva_pkg::PEDAL_THRESH);
               end else if (req_ccn inside {pva_pkg::CC_SOUND_OFF, pva_pkg::CC_NOTES_OFF}) begin
                  dec_kind = pva_pkg::KIND_ALL_OFF;
                  dec_work = 1'b1;
               end
            end
            default: dec_work = 1'b0;
         endcase
      end
   end

   // Slot under evaluation; a never-written slot reads as its reset value
   logic [ENT_W-1:0]    ent;
   logic                e_active, e_sus, e_held;
   logic [3:0]          e_chan;
   logic [6:0]          e_key;
   logic [AGE_BITS-1:0] e_age;

   assign ent      = valid_ff[idx_ff] ? ram_rdata : '0;
   assign e_active = ent[ACT_B];
   assign e_sus    = ent[SUS_B];
   assign e_held   = ent[HELD_B];
   assign e_chan   = ent[CHAN_LO +: 4];
   assign e_key    = ent[KEY_LO +: 7];
   assign e_age    = ent[AGE_LO +: AGE_BITS];

   // Per-slot match and modification
   logic e_match, e_emit, n_held, n_sus, n_act;

   always_comb begin
      e_match = 1'b0;
      e_emit  = 1'b0;
      n_held  = e_held;
      n_sus   = e_sus;
      n_act   = e_active;
      case (kind_ff)
         pva_pkg::KIND_DONE: begin
            e_match = 1'b1;
            n_held  = 1'b0;
            n_sus   = 1'b0;
            n_act   = 1'b0;
         end
         pva_pkg::KIND_OFF: begin
            e_match = e_held && (e_key == key_ff) && (e_chan == chan_ff);
            n_held  = 1'b0;
            n_sus   = pedal_ff[chan_ff];
            e_emit  = e_match && !pedal_ff[chan_ff];
         end
         pva_pkg::KIND_PEDAL: begin
            e_match = e_active && (e_chan == chan_ff) && e_sus && !e_held;
            n_sus   = 1'b0;
            e_emit  = e_match;
         end
         pva_pkg::KIND_ALL_OFF: begin
            e_match = e_active && (e_chan == chan_ff);
            n_held  = 1'b0;
            n_sus   = 1'b0;
            e_emit  = e_match;
         end
         default: e_match = 1'b0;
      endcase
   end

   logic stall, at_end, steal_better;
   logic [IDX_W-1:0] chosen;
   logic [AGE_BITS-1:0] new_age;

   assign stall   = (state_ff == pva_pkg::ST_EVAL) && e_emit && !buf_ready;
   assign at_end  = (idx_ff == end_ff);
   assign chosen  = free_found_ff ? free_idx_ff : best_idx_ff;
   assign new_age = age_ctr_ff + AGE_BITS'(1);
   // Released voices before held ones, then the oldest; ties to lowest index
   assign steal_better = (idx_ff == '0) ||
                         ((e_held != best_held_ff) ? !e_held : (e_age < best_age_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pva_pkg::ST_IDLE:
            if (accept && dec_work) state_in = pva_pkg::ST_EVAL;
         pva_pkg::ST_EVAL:
            if (!stall && at_end)
               state_in = (kind_ff == pva_pkg::KIND_ON) ? pva_pkg::ST_ONWR
                                                        : pva_pkg::ST_DRAIN;
         pva_pkg::ST_ONWR:
            if (buf_ready) state_in = pva_pkg::ST_DRAIN;
         pva_pkg::ST_DRAIN:
            if (buf_ready) state_in = pva_pkg::ST_IDLE;
         default: state_in = pva_pkg::ST_IDLE;
      endcase
   end

   // Outputs: handshake, RAM ports, result pushes
   always_comb begin
      req_tready  = 1'b0;
      ram_raddr   = idx_ff;
      ram_we      = 1'b0;
      ram_waddr   = idx_ff;
      ram_wdata   = {e_age, e_key, e_chan, n_held, n_sus, n_act};
      buf_ctl     = '0;
      case (state_ff)
         pva_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_raddr  = dec_start;
         end
         pva_pkg::ST_EVAL: begin
            if (!stall && !at_end) ram_raddr = idx_ff + IDX_W'(1);
            ram_we = e_match && !stall;
            buf_ctl.push             = e_emit;
            buf_ctl.res.voice_index  = 3'(idx_ff);
            buf_ctl.res.action       = pva_pkg::ACT_RELEASE;
            buf_ctl.res.out_key      = e_key;
            buf_ctl.res.out_chan     = e_chan;
            buf_ctl.res.out_velocity = 7'd0;
            buf_ctl.res.stolen       = 1'b0;
         end
         pva_pkg::ST_ONWR: begin
            ram_we    = buf_ready;
            ram_waddr = chosen;
            ram_wdata = {new_age, key_ff, chan_ff, 1'b1, 1'b0, 1'b1};
            buf_ctl.push             = 1'b1;
            buf_ctl.res.voice_index  = 3'(chosen);
            buf_ctl.res.action       = pva_pkg::ACT_START;
            buf_ctl.res.out_key      = key_ff;
            buf_ctl.res.out_chan     = chan_ff;
            buf_ctl.res.out_velocity = vel_ff;
            buf_ctl.res.stolen       = !free_found_ff;
         end
         pva_pkg::ST_DRAIN: buf_ctl.flush = 1'b1;
         default: req_tready = 1'b0;
      endcase
   end

   // Datapath next values
   always_comb begin
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      key_in        = key_ff;
      chan_in       = chan_ff;
      vel_in        = vel_ff;
      pedal_in      = pedal_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_held_in  = best_held_ff;
      best_age_in   = best_age_ff;
      age_ctr_in    = age_ctr_ff;
      for (int i = 0; i < NUM_VOICES; i++) begin
         valid_in[i] = valid_ff[i] || (ram_we && (ram_waddr == IDX_W'(i)));
      end
      case (state_ff)
         pva_pkg::ST_IDLE:
            if (accept) begin
               kind_in       = dec_kind;
               idx_in        = dec_start;
               end_in        = req_done ? dec_start : LAST_IDX;
               key_in        = req_key;
               chan_in       = req_chan;
               vel_in        = req_velocity;
               free_found_in = 1'b0;
               if (!req_done && req_command == pva_pkg::CMD_CTRL &&
                   req_ccn == pva_pkg::CC_SUSTAIN) begin
                  pedal_in[req_chan] = (req_ccv >= pva_pkg::PEDAL_THRESH);
               end
            end
         pva_pkg::ST_EVAL: begin
            if (!stall && !at_end) idx_in = idx_ff + IDX_W'(1);
            if (kind_ff == pva_pkg::KIND_ON) begin
               if (!e_active && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (steal_better) begin
                  best_idx_in  = idx_ff;
                  best_held_in = e_held;
                  best_age_in  = e_age;
               end
            end
         end
         pva_pkg::ST_ONWR:
            if (buf_ready) age_ctr_in = new_age;
         default: age_ctr_in = age_ctr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pva_pkg::ST_IDLE;
         pedal_ff   <= '0;
         valid_ff   <= '0;
         age_ctr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pedal_ff   <= pedal_in;
         valid_ff   <= valid_in;
         age_ctr_ff <= age_ctr_in;
      end
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      key_ff        <= key_in;
      chan_ff       <= chan_in;
      vel_ff        <= vel_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_held_ff  <= best_held_in;
      best_age_ff   <= best_age_in;
   end

   // The start result always finds the pending slot empty
   a_onwr_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == pva_pkg::ST_ONWR |-> buf_ready)
      else $error("note-on write found result buffer full");

   // A stalled slot is neither written nor skipped
   a_stall_no_write: assert property (@(posedge clock) disable iff (reset)
      stall |-> !ram_we)
      else $error("slot written while stalled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> (idx_ff == $past(idx_ff)) && (state_ff == pva_pkg::ST_EVAL))
      else $error("scan moved on while stalled");

   // Writes stay inside the voice table
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ram_waddr <= LAST_IDX)
      else $error("voice table write out of range");

endmodule

FILE: hdl/poly_voice_allocator.sv
// Polyphonic voice allocator, oldest-voice stealing with released voices taken first.
// Each note or controller event scans the voice table RAM one slot per cycle, a finished
// voice event only its own slot and an event with no effect none; the scan holds while
// the rsp side stalls.
// Reset (synchronous) frees all voices by clearing valid bits.
module poly_voice_allocator #(
   parameter int NUM_VOICES = 8,
   parameter int AGE_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // chan[3:0], key[10:4], velocity[17:11], controller_number[24:18],
   // controller_value[31:25], finished_voice[34:32]
   input  logic [pva_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[1:0], voice_done[2]
   input  logic [pva_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // voice_index[2:0], out_key[9:3], out_chan[13:10], out_velocity[20:14]
   output logic [pva_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // action[0], stolen[1]
   output logic [pva_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                           rsp_tlast
);

   localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int ENT_W = AGE_BITS + pva_pkg::ENT_FIXED_W;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [ENT_W-1:0]     ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [ENT_W-1:0]     ram_rdata;
   pva_pkg::buf_ctl_type buf_ctl;
   logic                 buf_ready;

   // Voice table
   pva_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_VOICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Event sequencer
   pva_ctrl #(
      .NUM_VOICES (NUM_VOICES),
      .AGE_BITS   (AGE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .buf_ctl    (buf_ctl),
      .buf_ready  (buf_ready)
   );

   // Result buffer and rsp stream
   pva_rsp_buf u_rsp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (buf_ctl),
      .ready      (buf_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
